### rtl/core/cse_pkg.sv
// ============================================================================
// cse_pkg
// Shared constants and types of the cosine similarity engine.
// ============================================================================
package cse_pkg;

  localparam int unsigned MaxDimDefault   = 4096;
  localparam int unsigned ElemBitsDefault = 16;

  // Result fields are fixed-point words with 15 fraction bits: similarity is signed Q1.15, drift unsigned UQ1.15.
  localparam int unsigned ResW      = 16;
  localparam int unsigned QBits     = 17;
  localparam int unsigned OneQ15    = 32768;
  localparam int unsigned MaxQ15    = 32767;
  localparam int unsigned MaxDrift  = 65535;
  localparam int unsigned SqW       = 32;

  // Depth of the queue between the front and the back.
  localparam int unsigned QueueDepth = 4;

  // Digit width of the shared sequential multiplier.
  localparam int unsigned DigitW = 8;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MULP = 6'b000010,
    ST_MULD = 6'b000100,
    ST_STEP = 6'b001000,
    ST_MULL = 6'b010000,
    ST_FIN  = 6'b100000
  } back_state_e;

endpackage

### rtl/core/cosine_similarity_engine.sv
// ============================================================================
// cosine_similarity_engine
// Streaming cosine similarity and drift of two vectors of Q1.15 elements.
// ============================================================================
//  Channel  | Direction | Handshake            | Word
//  ---------+-----------+----------------------+-------------------------------
//  in       | input     | in_valid_i/in_ready_o   | elem_a, elem_b, last_elem
//  out      | output    | out_valid_o/out_ready_i | similarity, drift, zero_norm,
//           |           |                      | overflow
//
// The front takes one element pair a cycle while the queue has room for two.
// The back works on one vector at a time, paced by the eight-bit-digit multiplier
// that it shares between the norm product, the squared dot and the search steps.
// A zero norm vector skips the multiplier and goes from idle straight to finish.
// Reset clears the sums, the queue and the back controller at once.
// A stalled output holds its word; the front keeps filling the queue meanwhile.
// ============================================================================
module cosine_similarity_engine #(
  parameter int unsigned MAX_DIM   = cse_pkg::MaxDimDefault,
  parameter int unsigned ELEM_BITS = cse_pkg::ElemBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [ELEM_BITS-1:0] elem_a_i,
  input  logic signed [ELEM_BITS-1:0] elem_b_i,
  input  logic                        last_elem_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [cse_pkg::ResW-1:0] similarity_o,
  output logic [cse_pkg::ResW-1:0]    drift_o,
  output logic                        zero_norm_o,
  output logic                        overflow_o
);

  localparam int unsigned CntW  = $clog2(MAX_DIM + 2);
  localparam int unsigned DotW  = 2 * ELEM_BITS + CntW;
  localparam int unsigned NormW = 2 * ELEM_BITS + CntW - 1;
  localparam int unsigned EntW  = DotW + 2 * NormW + 1;
  localparam int unsigned QD    = cse_pkg::QueueDepth;
  localparam int unsigned QCW   = $clog2(QD + 1);

  logic            acc;
  logic            push, pop, q_valid;
  logic [EntW-1:0] push_data, q_data;
  logic [QCW-1:0]  q_count;
  logic [cse_pkg::ResW-1:0] sim;

  assign in_ready_o = q_count <= QCW'(QD - 2);
  assign acc        = in_valid_i && in_ready_o;

  cse_front #(
    .MAX_DIM   (MAX_DIM),
    .ELEM_BITS (ELEM_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .elem_a_i    (elem_a_i),
    .elem_b_i    (elem_b_i),
    .last_elem_i (last_elem_i),
    .push_o      (push),
    .push_data_o (push_data)
  );

  cse_fifo #(
    .WIDTH (EntW),
    .DEPTH (QD)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_data),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (q_data),
    .count_o (q_count)
  );

  cse_back #(
    .MAX_DIM   (MAX_DIM),
    .ELEM_BITS (ELEM_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_data_i     (q_data),
    .q_pop_o      (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .similarity_o (sim),
    .drift_o      (drift_o),
    .zero_norm_o  (zero_norm_o),
    .overflow_o   (overflow_o)
  );

  assign similarity_o = signed'(sim);

endmodule

### rtl/core/cse_front.sv
// ============================================================================
// cse_front
// Accepts element pairs, forms the products and keeps the running sums.
// ============================================================================
module cse_front #(
  parameter int unsigned MAX_DIM   = cse_pkg::MaxDimDefault,
  parameter int unsigned ELEM_BITS = cse_pkg::ElemBitsDefault,
  localparam int unsigned CntW     = $clog2(MAX_DIM + 2),
  localparam int unsigned DotW     = 2 * ELEM_BITS + CntW,
  localparam int unsigned NormW    = 2 * ELEM_BITS + CntW - 1,
  localparam int unsigned EntW     = DotW + 2 * NormW + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        acc_i,
  input  logic signed [ELEM_BITS-1:0] elem_a_i,
  input  logic signed [ELEM_BITS-1:0] elem_b_i,
  input  logic                        last_elem_i,
  output logic                        push_o,
  output logic [EntW-1:0]             push_data_o
);

  localparam int unsigned PW = 2 * ELEM_BITS;
  localparam logic [CntW-1:0] MaxCnt  = CntW'(MAX_DIM);
  localparam logic [CntW-1:0] OverCnt = CntW'(MAX_DIM + 1);

  logic                 s1_valid_q, s1_last_q;
  logic signed [PW-1:0] pab_q, paa_q, pbb_q;
  logic [DotW-1:0]      dot_q, dot_d;
  logic [NormW-1:0]     na_q, na_d, nb_q, nb_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= acc_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      pab_q     <= elem_a_i * elem_b_i;
      paa_q     <= elem_a_i * elem_a_i;
      pbb_q     <= elem_b_i * elem_b_i;
      s1_last_q <= last_elem_i;
    end
  end

  always_comb begin
    dot_d = dot_q;
    na_d  = na_q;
    nb_d  = nb_q;
    if (cnt_q < MaxCnt) begin
      dot_d = dot_q + {{(DotW - PW){pab_q[PW-1]}}, pab_q};
      na_d  = na_q + NormW'(unsigned'(paa_q));
      nb_d  = nb_q + NormW'(unsigned'(pbb_q));
      cnt_d = cnt_q + CntW'(1);
    end else begin
      cnt_d = OverCnt;
    end
    ovf = cnt_d > MaxCnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= '0;
      na_q  <= '0;
      nb_q  <= '0;
      cnt_q <= '0;
    end else if (s1_valid_q) begin
      if (s1_last_q) begin
        dot_q <= '0;
        na_q  <= '0;
        nb_q  <= '0;
        cnt_q <= '0;
      end else begin
        dot_q <= dot_d;
        na_q  <= na_d;
        nb_q  <= nb_d;
        cnt_q <= cnt_d;
      end
    end
  end

  assign push_o      = s1_valid_q && s1_last_q;
  assign push_data_o = {ovf, nb_d, na_d, dot_d};

endmodule

### rtl/core/cse_fifo.sv
// ============================================================================
// cse_fifo
// Short queue of finished sums between the front and the back.
// ============================================================================
module cse_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = cse_pkg::QueueDepth,
  localparam int unsigned PtrW = $clog2(DEPTH),
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o,
  output logic [CntW-1:0]  count_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  assign valid_o = cnt_q != '0;
  assign rdata_o = mem_q[rptr_q];
  assign count_o = cnt_q;

endmodule

### rtl/core/cse_mul.sv
// ============================================================================
// cse_mul
// Sequential multiplier that takes one digit of the second operand a cycle.
// ============================================================================
module cse_mul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic             done_o,
  output logic [AW+BW-1:0] prod_o
);

  localparam int unsigned DW   = cse_pkg::DigitW;
  localparam int unsigned ND   = (BW + DW - 1) / DW;
  localparam int unsigned PBW  = ND * DW;
  localparam int unsigned AccW = AW + PBW;
  localparam int unsigned CntW = $clog2(ND + 1);

  logic [AW-1:0]    a_q;
  logic [PBW-1:0]   b_q;
  logic [AccW-1:0]  acc_q;
  logic [CntW-1:0]  cnt_q;
  logic             done_q;
  logic [AW+DW-1:0] pp;

  assign pp = a_q * b_q[PBW-1 -: DW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CntW'(ND);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= PBW'(b_i);
      acc_q <= '0;
    end else if (cnt_q != '0) begin
      acc_q <= (acc_q << DW) + AccW'(pp);
      b_q   <= b_q << DW;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q[AW+BW-1:0];

endmodule

### rtl/core/cse_back.sv
// ============================================================================
// cse_back
// Works out the rounded similarity by a binary search and holds the result.
// ============================================================================
module cse_back #(
  parameter int unsigned MAX_DIM   = cse_pkg::MaxDimDefault,
  parameter int unsigned ELEM_BITS = cse_pkg::ElemBitsDefault,
  localparam int unsigned CntW     = $clog2(MAX_DIM + 2),
  localparam int unsigned DotW     = 2 * ELEM_BITS + CntW,
  localparam int unsigned NormW    = 2 * ELEM_BITS + CntW - 1,
  localparam int unsigned EntW     = DotW + 2 * NormW + 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_valid_i,
  input  logic [EntW-1:0]          q_data_i,
  output logic                     q_pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [cse_pkg::ResW-1:0] similarity_o,
  output logic [cse_pkg::ResW-1:0] drift_o,
  output logic                     zero_norm_o,
  output logic                     overflow_o
);

  localparam int unsigned MA  = 2 * NormW;
  localparam int unsigned MB  = (DotW > cse_pkg::SqW) ? DotW : cse_pkg::SqW;
  localparam int unsigned DW2 = 2 * DotW;
  localparam int unsigned CW  = (MA + MB > DW2 + cse_pkg::SqW) ? MA + MB
                                                               : DW2 + cse_pkg::SqW;
  localparam int unsigned QB  = cse_pkg::QBits;
  localparam int unsigned RW  = cse_pkg::ResW;

  cse_pkg::back_state_e state_q, state_d;
  logic                 mul_start, mul_done;

  logic [DotW-1:0]    e_dot;
  logic [NormW-1:0]   e_na, e_nb;
  logic               e_ovf;
  logic [DotW-1:0]    dmag_q;
  logic               neg_q, zero_q, ovf_q;
  logic [MA-1:0]      p_q;
  logic [DW2-1:0]     d_q;
  logic [QB-1:0]      lo_q, hi_q, mid_q, mid;
  logic [QB:0]        odd;
  logic [cse_pkg::SqW-1:0] sq;
  logic [MA-1:0]      mul_a;
  logic [MB-1:0]      mul_b;
  logic [MA+MB-1:0]   mul_p;
  logic               fits;
  logic               out_valid_q;
  logic [RW-1:0]      sim_q, drift_q;
  logic               zflag_q, oflag_q;
  logic [RW-1:0]      sim_n, drift_n;
  logic [QB:0]        drift_w;
  logic               take;

  assign {e_ovf, e_nb, e_na, e_dot} = q_data_i;

  assign mid  = lo_q + ((hi_q - lo_q + QB'(1)) >> 1);
  assign odd  = {mid, 1'b0} - (QB + 1)'(1);
  assign sq   = odd[RW-1:0] * odd[RW-1:0];
  assign fits = CW'(mul_p) <= CW'({d_q, {cse_pkg::SqW{1'b0}}});
  assign take = !out_valid_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    q_pop_o   = 1'b0;
    mul_start = 1'b0;
    mul_a     = MA'(e_na);
    mul_b     = MB'(e_nb);
    case (state_q)
      cse_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (e_na == '0 || e_nb == '0) begin
            state_d = cse_pkg::ST_FIN;
          end else begin
            mul_start = 1'b1;
            state_d   = cse_pkg::ST_MULP;
          end
        end
      end
      cse_pkg::ST_MULP: begin
        mul_a = MA'(dmag_q);
        mul_b = MB'(dmag_q);
        if (mul_done) begin
          mul_start = 1'b1;
          state_d   = cse_pkg::ST_MULD;
        end
      end
      cse_pkg::ST_MULD: begin
        if (mul_done) begin
          state_d = cse_pkg::ST_STEP;
        end
      end
      cse_pkg::ST_STEP: begin
        mul_a = p_q;
        mul_b = MB'(sq);
        if (lo_q < hi_q) begin
          mul_start = 1'b1;
          state_d   = cse_pkg::ST_MULL;
        end else begin
          state_d = cse_pkg::ST_FIN;
        end
      end
      cse_pkg::ST_MULL: begin
        if (mul_done) begin
          state_d = cse_pkg::ST_STEP;
        end
      end
      cse_pkg::ST_FIN: begin
        if (take) begin
          state_d = cse_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cse_pkg::ST_IDLE;
      end
    endcase
  end

  cse_mul #(
    .AW (MA),
    .BW (MB)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cse_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      neg_q  <= e_dot[DotW-1];
      dmag_q <= e_dot[DotW-1] ? (~e_dot + DotW'(1)) : e_dot;
      zero_q <= (e_na == '0) || (e_nb == '0);
      ovf_q  <= e_ovf;
      lo_q   <= '0;
      hi_q   <= QB'(cse_pkg::OneQ15);
    end
    if (state_q == cse_pkg::ST_MULP && mul_done) begin
      p_q <= mul_p[MA-1:0];
    end
    if (state_q == cse_pkg::ST_MULD && mul_done) begin
      d_q <= mul_p[DW2-1:0];
    end
    if (state_q == cse_pkg::ST_STEP) begin
      mid_q <= mid;
    end
    if (state_q == cse_pkg::ST_MULL && mul_done) begin
      if (fits) begin
        lo_q <= mid_q;
      end else begin
        hi_q <= mid_q - QB'(1);
      end
    end
  end

  always_comb begin
    if (neg_q) begin
      drift_w = (QB + 1)'(cse_pkg::OneQ15) + (QB + 1)'(lo_q);
      sim_n   = RW'(~lo_q + QB'(1));
    end else begin
      drift_w = (QB + 1)'(cse_pkg::OneQ15) - (QB + 1)'(lo_q);
      sim_n   = (lo_q == QB'(cse_pkg::OneQ15)) ? RW'(cse_pkg::MaxQ15) : RW'(lo_q);
    end
    drift_n = (drift_w > (QB + 1)'(cse_pkg::MaxDrift)) ? RW'(cse_pkg::MaxDrift)
                                                      : RW'(drift_w);
    if (zero_q) begin
      sim_n   = '0;
      drift_n = RW'(cse_pkg::OneQ15);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == cse_pkg::ST_FIN && take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == cse_pkg::ST_FIN && take) begin
      sim_q   <= sim_n;
      drift_q <= drift_n;
      zflag_q <= zero_q;
      oflag_q <= ovf_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign similarity_o = sim_q;
  assign drift_o      = drift_q;
  assign zero_norm_o  = zflag_q;
  assign overflow_o   = oflag_q;

  a_search_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cse_pkg::ST_STEP) |-> (lo_q <= hi_q))
    else $error("search bounds crossed");

  a_search_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cse_pkg::ST_STEP) |-> (hi_q <= QB'(cse_pkg::OneQ15)))
    else $error("search bound above one");

  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == cse_pkg::ST_MULP || state_q == cse_pkg::ST_MULD ||
                  state_q == cse_pkg::ST_MULL))
    else $error("multiplier finished outside a wait state");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i)
    else $error("pop from an empty queue");

endmodule
